/* hdl/ncbs_pkg.sv */
// Shared types, constants and helpers for the nearest-center binary search block.
package ncbs_pkg;

    // Default table depth handed to the top level.
    localparam int DEF_TABLE_DEPTH = 64;

    // Field widths of the stream items.
    localparam int POS_W      = 32;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int NEAREST_W  = 6;
    localparam int INTERVAL_W = 7;

    // Packed stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Width of the shared subtractor: a difference of two differences of positions.
    localparam int SUB_W = POS_W + 2;

    // Result of the shared subtractor.
    typedef struct packed {
        logic signed [SUB_W-1:0] diff;
        logic                    neg;
        logic                    zero;
    } sub_res_t;

    // Sign-extends a position to the subtractor width.
    function automatic logic signed [SUB_W-1:0] sext_pos(input logic signed [POS_W-1:0] v);
        return {{(SUB_W-POS_W){v[POS_W-1]}}, v};
    endfunction

endpackage

/* hdl/ncbs_table.sv */
// Center position table: one write port and two registered read ports.
module ncbs_table
    import ncbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [POS_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr_a,
    input  logic [AW-1:0]           rd_addr_b,
    output logic signed [POS_W-1:0] rd_data_a,
    output logic signed [POS_W-1:0] rd_data_b
);

    logic signed [POS_W-1:0] mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* hdl/ncbs_sub.sv */
// Shared subtractor used for every compare and distance test of the search.
module ncbs_sub
    import ncbs_pkg::*;
(
    input  logic signed [SUB_W-1:0] a,
    input  logic signed [SUB_W-1:0] b,
    output sub_res_t                res
);

    // One wide subtract; sign and zero flags serve as the compare outcome.
    always_comb
    begin
        res.diff = a - b;
        res.neg  = res.diff[SUB_W-1];
        res.zero = (res.diff == '0);
    end

endmodule

/* hdl/nearest_center_binary_search.sv */
// Top level: table of centers, shared subtractor and the search sequencer.
//
//  Channel  Ports                         Direction  Contents
//  s_axis   tvalid tready tdata tuser     in         load or query item
//  m_axis   tvalid tready tdata           out        one result per query
//  cfg      cfg_we cfg_wdata              in         entry_count register
//
// A load item is written to the table on its transfer. A query passes through the
// transfer, a test of the last and then the first entry in use, the halving steps
// (a table read and up to two subtractor passes each), a pick of the nearer center
// and the load of the output register; an end hit or an empty window skips to the load.
// Reset clears the sequencer and sets entry_count to 1; table contents are
// undefined until loaded. A stalled result waits in the output register.
module nearest_center_binary_search
    import ncbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // entry_index[5:0], position[37:6], zero pad
    input  logic [0:0]             s_axis_tuser,   // req_type[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // nearest_index[5:0], interval_index[12:6]
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_END_HI = 8'b0000_0010,
        ST_END_LO = 8'b0000_0100,
        ST_ISSUE  = 8'b0000_1000,
        ST_CMP_LO = 8'b0001_0000,
        ST_CMP_HI = 8'b0010_0000,
        ST_NEAR   = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      entry_count_reg;
    logic signed [POS_W-1:0] key_reg, key_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           iv_reg, iv_next;
    logic [CW-1:0]           near_reg, near_next;
    logic signed [SUB_W-1:0] dlo_reg, dlo_next;
    logic signed [SUB_W-1:0] dhi_reg, dhi_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                    in_type;
    logic [SLOT_W-1:0]       in_slot;
    logic signed [POS_W-1:0] in_pos;
    logic                    s_xfer;
    logic                    out_load;

    logic [CW+COUNT_W-1:0]   count_wide;
    logic [CW-1:0]           n_sel;
    logic [CW-1:0]           n_sel_m1;
    logic [CW+SLOT_W-1:0]    slot_wide;
    logic                    slot_ok;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_calc;
    logic [CW-1:0]           mid_calc_m1;
    logic [CW+INTERVAL_W-1:0] iv_wide;
    logic [CW+NEAREST_W-1:0] near_wide;

    logic                    tbl_we;
    logic                    tbl_re;
    logic [AW-1:0]           tbl_addr_a;
    logic [AW-1:0]           tbl_addr_b;
    logic signed [POS_W-1:0] tbl_data_a;
    logic signed [POS_W-1:0] tbl_data_b;

    logic signed [SUB_W-1:0] sub_a;
    logic signed [SUB_W-1:0] sub_b;
    sub_res_t                sub_res;

    // Input field unpacking and transfer detect.
    assign in_type = s_axis_tuser[0];
    assign in_slot = s_axis_tdata[SLOT_W-1:0];
    assign in_pos  = s_axis_tdata[SLOT_W+POS_W-1:SLOT_W];
    assign s_xfer  = s_axis_tvalid && s_axis_tready;

    // Entry count clamped to one through the table depth.
    assign count_wide = {{CW{1'b0}}, entry_count_reg};
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            n_sel = CW'(1);
        end
        else if (count_wide > (CW+COUNT_W)'(TABLE_DEPTH))
        begin
            n_sel = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_sel = count_wide[CW-1:0];
        end
    end
    assign n_sel_m1 = n_sel - CW'(1);

    // Loads beyond the table depth are dropped.
    assign slot_wide = {{CW{1'b0}}, in_slot};
    assign slot_ok   = (slot_wide < (CW+SLOT_W)'(TABLE_DEPTH));

    // Midpoint of the current search window.
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc    = mid_sum[CW:1];
    assign mid_calc_m1 = mid_calc - CW'(1);

    // Result fields masked to their widths.
    assign iv_wide   = {{INTERVAL_W{1'b0}}, iv_reg};
    assign near_wide = {{NEAREST_W{1'b0}}, near_reg};

    ncbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk       (clk),
        .wr_en     (tbl_we),
        .wr_addr   (slot_wide[AW-1:0]),
        .wr_data   (in_pos),
        .rd_en     (tbl_re),
        .rd_addr_a (tbl_addr_a),
        .rd_addr_b (tbl_addr_b),
        .rd_data_a (tbl_data_a),
        .rd_data_b (tbl_data_b)
    );

    ncbs_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    // Search sequencer.
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        iv_next    = iv_reg;
        near_next  = near_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        tbl_we     = 1'b0;
        tbl_re     = 1'b0;
        tbl_addr_a = '0;
        tbl_addr_b = '0;
        sub_a      = sext_pos(key_reg);
        sub_b      = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (in_type == REQ_QUERY)
                    begin
                        // Read the last and the first entry in use.
                        key_next   = in_pos;
                        n_next     = n_sel;
                        tbl_re     = 1'b1;
                        tbl_addr_a = n_sel_m1[AW-1:0];
                        tbl_addr_b = '0;
                        state_next = ST_END_HI;
                    end
                    else
                    begin
                        tbl_we = slot_ok;
                    end
                end
            end
            ST_END_HI:
            begin
                // Key at or above the last entry selects the last entry.
                sub_b = sext_pos(tbl_data_a);
                if (!sub_res.neg)
                begin
                    iv_next    = n_reg;
                    near_next  = n_reg - CW'(1);
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_END_LO;
                end
            end
            ST_END_LO:
            begin
                // Key below the first entry selects entry zero.
                sub_b = sext_pos(tbl_data_b);
                if (sub_res.neg)
                begin
                    iv_next    = '0;
                    near_next  = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    lo_next    = CW'(1);
                    hi_next    = n_reg - CW'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (hi_reg >= lo_reg)
                begin
                    mid_next   = mid_calc;
                    tbl_re     = 1'b1;
                    tbl_addr_a = mid_calc_m1[AW-1:0];
                    tbl_addr_b = mid_calc[AW-1:0];
                    state_next = ST_CMP_LO;
                end
                else
                begin
                    // Window empty: no interval found.
                    iv_next    = '0;
                    near_next  = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_CMP_LO:
            begin
                // Distance from the lower bound; negative means search lower.
                sub_b    = sext_pos(tbl_data_a);
                dlo_next = sub_res.diff;
                if (sub_res.neg)
                begin
                    hi_next    = mid_reg - CW'(1);
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_CMP_HI;
                end
            end
            ST_CMP_HI:
            begin
                // Distance to the upper bound; positive means the key is inside.
                sub_a = sext_pos(tbl_data_b);
                sub_b = sext_pos(key_reg);
                if (!sub_res.neg && !sub_res.zero)
                begin
                    iv_next    = mid_reg;
                    dhi_next   = sub_res.diff;
                    state_next = ST_NEAR;
                end
                else
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_NEAR:
            begin
                // Lower center wins only when strictly closer.
                sub_a = dlo_reg;
                sub_b = dhi_reg;
                if (sub_res.neg)
                begin
                    near_next = mid_reg - CW'(1);
                end
                else
                begin
                    near_next = mid_reg;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(OUT_TDATA_W-INTERVAL_W-NEAREST_W){1'b0}},
                             iv_wide[INTERVAL_W-1:0], near_wide[NEAREST_W-1:0]};
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            entry_count_reg <= COUNT_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        n_reg       <= n_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        iv_reg      <= iv_next;
        near_reg    <= near_next;
        dlo_reg     <= dlo_next;
        dhi_reg     <= dhi_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

/* hdl/ncbs_checker.sv */
// Port-level checks for the nearest-center search, bound to the top level.
module ncbs_checker
    import ncbs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [NEAREST_W-1:0]  chk_near;
    logic [INTERVAL_W-1:0] chk_iv;

    assign chk_near = m_axis_tdata[NEAREST_W-1:0];
    assign chk_iv   = m_axis_tdata[NEAREST_W+INTERVAL_W-1:NEAREST_W];

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // The nearest center bounds the reported interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (chk_iv == '0 && chk_near == '0)
                          || ({1'b0, chk_near} == chk_iv)
                          || (chk_iv != '0 && {1'b0, chk_near} == chk_iv - 7'd1))
    else $error("nearest index outside the interval");

    // A load transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
    else $error("result after a load transfer");

    // A query keeps the input side busy while the search runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_QUERY |=> !s_axis_tready)
    else $error("input ready during a search");

endmodule

bind nearest_center_binary_search ncbs_checker u_ncbs_checker (.*);
